// ===== design/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color block.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int COLOR_W       = 8;
    localparam int ENTRY_W       = 3 * COLOR_W;
    localparam int IDX_W         = 8;
    localparam int SIZE_W        = 9;
    localparam int SQ_W          = 2 * COLOR_W;
    localparam int DIST_W        = SQ_W + 2;
    localparam int DEPTH_DEFAULT = 256;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

// ===== design/npc_ram.sv =====
// ----------------------------------------------------------------------------
// npc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module npc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/npc_dist.sv =====
// ----------------------------------------------------------------------------
// npc_dist
// Shared distance unit: squared RGB distance between the held pixel and one
// palette entry per cycle, two register stages, tag carried alongside.
// ----------------------------------------------------------------------------
module npc_dist
    import npc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [COLOR_W-1:0] i_red,
    input  logic [COLOR_W-1:0] i_green,
    input  logic [COLOR_W-1:0] i_blue,
    input  logic [ENTRY_W-1:0] i_entry,
    input  t_tag               i_tag,
    output logic [DIST_W-1:0]  o_dist,
    output t_tag               o_tag
);

    logic [COLOR_W-1:0] r_red, r_green, r_blue;
    logic [COLOR_W-1:0] w_er, w_eg, w_eb;
    logic [COLOR_W-1:0] w_dr, w_dg, w_db;
    logic [SQ_W-1:0]    r_sq_r, r_sq_g, r_sq_b;
    logic [DIST_W-1:0]  r_dist;
    t_tag               r_tag1, r_tag2;

    assign w_er = i_entry[ENTRY_W-1 -: COLOR_W];
    assign w_eg = i_entry[SQ_W-1 -: COLOR_W];
    assign w_eb = i_entry[COLOR_W-1:0];

    assign w_dr = (r_red   > w_er) ? (r_red   - w_er) : (w_er - r_red);
    assign w_dg = (r_green > w_eg) ? (r_green - w_eg) : (w_eg - r_green);
    assign w_db = (r_blue  > w_eb) ? (r_blue  - w_eb) : (w_eb - r_blue);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
        r_sq_r <= SQ_W'(w_dr) * SQ_W'(w_dr);
        r_sq_g <= SQ_W'(w_dg) * SQ_W'(w_dg);
        r_sq_b <= SQ_W'(w_db) * SQ_W'(w_db);
        r_dist <= DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    assign o_dist = r_dist;
    assign o_tag  = r_tag2;

endmodule

// ===== design/npc_ctrl.sv =====
// ----------------------------------------------------------------------------
// npc_ctrl
// Sequencer: accepts beats, walks the palette read address, keeps the running
// best entry and holds the result in the output register.
// ----------------------------------------------------------------------------
module npc_ctrl
    import npc_pkg::*;
#(
    parameter int PALETTE_DEPTH = DEPTH_DEFAULT,
    localparam int AW           = $clog2(PALETTE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [SIZE_W-1:0] i_palette_size,
    output logic              o_wr_en,
    output logic              o_load_px,
    output logic [AW-1:0]     o_rd_addr,
    output t_tag              o_tag,
    input  logic [DIST_W-1:0] i_dist,
    input  t_tag              i_dist_tag,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [IDX_W-1:0]  o_best_index
);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_rd_idx, n_rd_idx;
    logic [AW-1:0]      r_last, n_last;
    logic [AW-1:0]      w_last;
    logic               r_o_valid, n_o_valid;
    logic [IDX_W-1:0]   r_o_best, n_o_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic [DIST_W-1:0]  r_best_dist;
    logic               w_issue;
    logic               w_better;
    t_tag               w_tag_issue;
    t_tag               r_tag_ram;

    always_comb begin
        if (i_palette_size == '0) begin
            w_last = '0;
        end else if (i_palette_size > SIZE_W'(PALETTE_DEPTH)) begin
            w_last = AW'(PALETTE_DEPTH - 1);
        end else begin
            w_last = AW'(i_palette_size - 1'b1);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_rd_idx  = r_rd_idx;
        n_last    = r_last;
        n_o_valid = r_o_valid && !i_ready;
        n_o_best  = r_o_best;
        o_ready   = 1'b0;
        o_load_px = 1'b0;
        o_wr_en   = 1'b0;
        w_issue   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_op == OP_QUERY) begin
                        o_load_px = 1'b1;
                        n_rd_idx  = '0;
                        n_last    = w_last;
                        n_state   = S_SEARCH;
                    end else begin
                        o_wr_en = 1'b1;
                    end
                end
            end
            S_SEARCH: begin
                w_issue = 1'b1;
                if (r_rd_idx == r_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_dist_tag.valid && i_dist_tag.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_best  = r_best_idx;
                    n_state   = S_IDLE;
                end
            end
        endcase
    end

    assign w_tag_issue = '{valid: w_issue, last: (r_rd_idx == r_last),
                           idx: IDX_W'(r_rd_idx)};

    assign w_better = i_dist_tag.valid &&
                      ((i_dist_tag.idx == '0) || (i_dist < r_best_dist));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_o_valid       <= 1'b0;
            r_tag_ram.valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_tag_ram <= w_tag_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_last   <= n_last;
        r_o_best <= n_o_best;
        if (w_better) begin
            r_best_idx  <= i_dist_tag.idx;
            r_best_dist <= i_dist;
        end
    end

    assign o_rd_addr    = r_rd_idx;
    assign o_tag        = r_tag_ram;
    assign o_valid      = r_o_valid;
    assign o_best_index = r_o_best;

endmodule

// ===== design/nearest_palette_color_top.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_top
// Nearest palette color lookup: stores an RGB palette and returns the index of
// the entry closest to a pixel by squared Euclidean distance.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_ready   i_op, i_entry_index, i_red,
//                                            i_green, i_blue
//   result    out        o_valid / i_ready   o_best_index
//   config    in         i_cfg_we            i_cfg_data (palette_size)
//
// A load beat is one write to the single-port palette RAM.
// A query beat searches N entries, N the clamped palette_size: the search reads
// one entry per cycle from the palette RAM into one shared distance unit.
// The result sits in an output register; loads keep flowing while it waits.
// A query whose result finds the output register still full holds until it drains.
// Reset clears control state only; palette contents are unknown until loaded.
// ----------------------------------------------------------------------------
module nearest_palette_color_top
    import npc_pkg::*;
#(
    parameter int PALETTE_DEPTH = DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic [COLOR_W-1:0] i_red,
    input  logic [COLOR_W-1:0] i_green,
    input  logic [COLOR_W-1:0] i_blue,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [IDX_W-1:0]   o_best_index,
    input  logic               i_cfg_we,
    input  logic [SIZE_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [SIZE_W-1:0]  r_palette_size;
    logic               w_wr_en;
    logic               w_load_px;
    logic [AW-1:0]      w_rd_addr;
    logic               w_ram_we;
    logic [AW-1:0]      w_ram_addr;
    logic [ENTRY_W-1:0] w_rdata;
    t_tag               w_ram_tag;
    t_tag               w_dist_tag;
    logic [DIST_W-1:0]  w_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_palette_size <= i_cfg_data;
        end
    end

    assign w_ram_we   = w_wr_en && ({1'b0, i_entry_index} < SIZE_W'(PALETTE_DEPTH));
    assign w_ram_addr = w_wr_en ? i_entry_index[AW-1:0] : w_rd_addr;

    npc_ctrl #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_palette_size (r_palette_size),
        .o_wr_en        (w_wr_en),
        .o_load_px      (w_load_px),
        .o_rd_addr      (w_rd_addr),
        .o_tag          (w_ram_tag),
        .i_dist         (w_dist),
        .i_dist_tag     (w_dist_tag),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_best_index   (o_best_index)
    );

    npc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata ({i_red, i_green, i_blue}),
        .o_rdata (w_rdata)
    );

    npc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load_px),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .i_entry (w_rdata),
        .i_tag   (w_ram_tag),
        .o_dist  (w_dist),
        .o_tag   (w_dist_tag)
    );

`ifndef SYNTHESIS
    a_query_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_op == OP_QUERY) |=> !o_ready)
        else $error("ready stayed high after a query beat");

    a_write_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (o_ready && !w_ram_tag.valid && !w_dist_tag.valid))
        else $error("palette write during a search");

    a_best_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_best_index} < SIZE_W'(PALETTE_DEPTH)))
        else $error("best index beyond palette depth");

    a_search_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without a search ending");
`endif

endmodule

// ===== dv/nearest_palette_color_checker.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_checker
// Watches the input, result and register ports of the nearest palette color
// block. It keeps a shadow palette and palette size, computes the expected
// best index for every accepted query beat, and compares each result beat in
// order. Mismatches and unexpected result beats are counted.
// ----------------------------------------------------------------------------
module nearest_palette_color_checker
    import npc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_op,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic [COLOR_W-1:0] i_red,
    input  logic [COLOR_W-1:0] i_green,
    input  logic [COLOR_W-1:0] i_blue,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [IDX_W-1:0]   i_best_index,
    input  logic               i_cfg_we,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    output int                 o_error_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEPTH_DEFAULT;

    logic [ENTRY_W-1:0] shadow_palette [DEPTH];
    logic [SIZE_W-1:0]  shadow_size = SIZE_RESET;
    logic [IDX_W-1:0]   expected_best_q [$];

    function automatic logic [SQ_W-1:0] channel_sq(logic [COLOR_W-1:0] a,
                                                   logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    function automatic logic [DIST_W-1:0] color_dist(logic [COLOR_W-1:0] r,
                                                     logic [COLOR_W-1:0] g,
                                                     logic [COLOR_W-1:0] b,
                                                     logic [ENTRY_W-1:0] entry);
        return DIST_W'(channel_sq(r, entry[23:16])) + DIST_W'(channel_sq(g, entry[15:8]))
             + DIST_W'(channel_sq(b, entry[7:0]));
    endfunction

    function automatic logic [IDX_W-1:0] nearest_entry(logic [COLOR_W-1:0] r,
                                                       logic [COLOR_W-1:0] g,
                                                       logic [COLOR_W-1:0] b);
        int                 count;
        logic [DIST_W-1:0]  cand_dist;
        logic [DIST_W-1:0]  best_dist;
        logic [IDX_W-1:0]   best;
        count = int'(shadow_size);
        if (count < 1) count = 1;
        if (count > DEPTH) count = DEPTH;
        best      = '0;
        best_dist = color_dist(r, g, b, shadow_palette[0]);
        for (int i = 1; i < count; i++) begin
            cand_dist = color_dist(r, g, b, shadow_palette[i]);
            if (cand_dist < best_dist) begin
                best_dist = cand_dist;
                best      = IDX_W'(i);
            end
        end
        return best;
    endfunction

    always @(posedge i_clk) begin
        logic [IDX_W-1:0] want;
        if (!i_rst_n) begin
            shadow_size <= SIZE_RESET;
            expected_best_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_best_q.size() == 0) begin
                    $error("best_index: expected none, actual %0d", i_best_index);
                    o_error_count <= o_error_count + 1;
                end else begin
                    want = expected_best_q.pop_front();
                    if (i_best_index !== want) begin
                        $error("best_index: expected %0d, actual %0d", want, i_best_index);
                        o_error_count <= o_error_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_op == OP_LOAD) begin
                    shadow_palette[i_entry_index] <= {i_red, i_green, i_blue};
                end else begin
                    expected_best_q.push_back(nearest_entry(i_red, i_green, i_blue));
                end
            end
            if (i_cfg_we) begin
                shadow_size <= i_cfg_data;
            end
            o_pending <= expected_best_q.size();
        end
    end

endmodule

// ===== dv/tb_nearest_palette_color_top.sv =====
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_top
// Drives the nearest palette color block through a directed opening (color
// extremes, ties, size zero and one) and then random phases of load and
// query beats at several palette sizes, with sender gaps, receiver stalls
// and a long receiver hold-off. Queries only reach palette slots that were
// loaded. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_top;
    import npc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int IDLE_WAIT  = 270;
    localparam int HOLD_LEN   = 400;
    localparam int NUM_PHASES = 9;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic               i_op          = OP_LOAD;
    logic [IDX_W-1:0]   i_entry_index = '0;
    logic [COLOR_W-1:0] i_red         = '0;
    logic [COLOR_W-1:0] i_green       = '0;
    logic [COLOR_W-1:0] i_blue        = '0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic [IDX_W-1:0]   o_best_index;
    logic               i_cfg_we      = 1'b0;
    logic [SIZE_W-1:0]  i_cfg_data    = '0;

    int error_count;
    int pending;

    bit                 palette_loaded [DEPTH];
    logic [ENTRY_W-1:0] palette_shade [DEPTH];
    int                 search_len         = DEPTH;
    int                 sender_gap_pct     = 0;
    int                 receiver_stall_pct = 0;
    bit                 hold_req           = 1'b0;
    bit                 hold_seen          = 1'b0;
    int                 hold_left          = 0;

    nearest_palette_color_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_best_index  (o_best_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    nearest_palette_color_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_op          (i_op),
        .i_entry_index (i_entry_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_best_index  (o_best_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic drive_beat(logic op, logic [IDX_W-1:0] idx, logic [ENTRY_W-1:0] rgb);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_entry_index <= idx;
        i_red         <= rgb[23:16];
        i_green       <= rgb[15:8];
        i_blue        <= rgb[7:0];
        do @(posedge i_clk); while (!o_ready);
        if (op == OP_LOAD) begin
            palette_loaded[idx] = 1'b1;
            palette_shade[idx]  = rgb;
        end
    endtask

    task automatic set_palette_size(logic [SIZE_W-1:0] size);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        search_len = (size < 1) ? 1 : (size > DEPTH) ? DEPTH : int'(size);
    endtask

    task automatic random_beat();
        logic [ENTRY_W-1:0] rgb;
        logic [IDX_W-1:0]   idx;
        int unsigned        pick;
        pick = $urandom_range(7);
        if (pick == 0) begin
            rgb = palette_shade[$urandom_range(search_len - 1)];
        end else if (pick == 1) begin
            rgb = {($urandom_range(1) ? 8'hFF : 8'h00), ($urandom_range(1) ? 8'hFF : 8'h00),
                   ($urandom_range(1) ? 8'hFF : 8'h00)};
        end else begin
            rgb = ENTRY_W'($urandom);
        end
        if ($urandom_range(99) < 60) begin
            drive_beat(OP_QUERY, IDX_W'($urandom), rgb);
        end else begin
            idx = $urandom_range(1) ? IDX_W'($urandom_range(search_len - 1))
                                    : IDX_W'($urandom_range(DEPTH - 1));
            drive_beat(OP_LOAD, idx, rgb);
        end
    endtask

    initial begin
        int phase_size  [NUM_PHASES] = '{7, 16, 3, 32, 256, 511, 1, 12, 0};
        int phase_gap   [NUM_PHASES] = '{0, 54, 0, 26, 0, 54, 0, 26, 0};
        int phase_stall [NUM_PHASES] = '{0, 0, 54, 26, 0, 54, 0, 26, 54};
        int phase_beats [NUM_PHASES] = '{250, 250, 250, 250, 100, 80, 100, 250, 220};
        bit phase_hold  [NUM_PHASES] = '{0, 0, 1, 0, 0, 0, 0, 1, 0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_palette_size(SIZE_W'(4));
        drive_beat(OP_LOAD, 8'd0, 24'h000000);
        drive_beat(OP_LOAD, 8'd1, 24'hFFFFFF);
        drive_beat(OP_LOAD, 8'd2, 24'hFF0000);
        drive_beat(OP_LOAD, 8'd3, 24'h000000);
        drive_beat(OP_LOAD, 8'hFF, 24'h00FF00);
        drive_beat(OP_QUERY, 8'd0, 24'h000000);
        drive_beat(OP_QUERY, 8'hFF, 24'hFFFFFF);
        drive_beat(OP_QUERY, 8'h5A, 24'hFF0000);
        drive_beat(OP_QUERY, 8'd0, 24'h808080);
        drive_beat(OP_QUERY, 8'hA5, 24'h0000FF);
        drive_beat(OP_LOAD, 8'd2, 24'h0000FF);
        drive_beat(OP_QUERY, 8'd0, 24'h0000FE);
        drive_beat(OP_LOAD, 8'd3, 24'h0A0000);
        drive_beat(OP_LOAD, 8'd0, 24'h000A00);
        drive_beat(OP_QUERY, 8'd0, 24'h000000);
        set_palette_size(SIZE_W'(0));
        drive_beat(OP_QUERY, 8'd7, 24'hFFFFFF);
        set_palette_size(SIZE_W'(1));
        drive_beat(OP_QUERY, 8'd0, 24'h00FF00);

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_palette_size(SIZE_W'(phase_size[p] != 0 ? phase_size[p]
                                                        : $urandom_range(64, 2)));
            sender_gap_pct     = phase_gap[p];
            receiver_stall_pct = phase_stall[p];
            for (int i = 0; i < search_len; i++) begin
                if (!palette_loaded[i]) drive_beat(OP_LOAD, IDX_W'(i), ENTRY_W'($urandom));
            end
            if (phase_hold[p]) hold_req = !hold_req;
            for (int n = 0; n < phase_beats[p]; n++) begin
                random_beat();
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
